// ----- rtl/core/dst_pkg.sv -----
// Package: constants, types and tables shared by the direction source tracker.
`default_nettype none
package dst_pkg;
	localparam int MaxSourcesDef = 6;
	localparam int CordicSteps   = 16;
	localparam int AngW          = 9;
	localparam int ZW            = 26;
	localparam logic [7:0] SpreadReset = 8'd15;

	localparam logic [2:0] EV_NEW       = 3'd0;
	localparam logic [2:0] EV_NEW_TURN  = 3'd1;
	localparam logic [2:0] EV_CONTINUE  = 3'd2;
	localparam logic [2:0] EV_AMBIGUOUS = 3'd3;
	localparam logic [2:0] EV_FULL      = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CORDIC, ST_ANGLE, ST_SCAN, ST_APPLY, ST_DIV, ST_DONE
	} state_t;

	function automatic logic [ZW-1:0] atan_lut(input logic [3:0] i);
		logic [ZW-1:0] r;
		unique case (i)
			4'd0: r = 26'd2949120;  4'd1: r = 26'd1740967;
			4'd2: r = 26'd919879;   4'd3: r = 26'd466945;
			4'd4: r = 26'd234379;   4'd5: r = 26'd117304;
			4'd6: r = 26'd58666;    4'd7: r = 26'd29335;
			4'd8: r = 26'd14668;    4'd9: r = 26'd7334;
			4'd10: r = 26'd3667;    4'd11: r = 26'd1833;
			4'd12: r = 26'd917;     4'd13: r = 26'd458;
			4'd14: r = 26'd229;     default: r = 26'd115;
		endcase
		return r;
	endfunction

	function automatic logic signed [AngW-1:0] wrap180(input logic signed [AngW+1:0] a);
		logic signed [AngW+1:0] r;
		if (a > 11'sd180) r = a - 11'sd360;
		else if (a < -11'sd180) r = a + 11'sd360;
		else r = a;
		return r[AngW-1:0];
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/direction_source_tracker.sv -----
// Top level: direction source tracker with APB register and stream ports.
// Flow: 16 CORDIC steps, angle capture, a scan of the N stored sources and apply, then 24
// divider steps when one match with nonzero frequency updates the mean.
// Frames: one at a time; s_tready is low while a frame is in work, until the result is taken.
// Reset: arst_n asynchronous active low clears the table and sets the match window to 15.
`default_nettype none
module direction_source_tracker import dst_pkg::*; #(
	parameter int MAX_SOURCES = MaxSourcesDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // [15:0] pos_x, [31:16] pos_y, [55:32] frequency
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [2:0] event_res, rest zero
);
	localparam int IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CW = $clog2(MAX_SOURCES + 1);

	logic [7:0] spread_q;
	state_t     state_q, state_d;

	// entry table in flip-flops, entries read by the scan index and by the hit index
	logic signed [AngW-1:0] ang_q   [MAX_SOURCES];
	logic [4:0]             led_q   [MAX_SOURCES];
	logic [MAX_SOURCES-1:0] talk_q;
	logic [15:0]            turns_q [MAX_SOURCES];
	logic [31:0]            ticks_q [MAX_SOURCES];
	logic [23:0]            mean_q  [MAX_SOURCES];
	logic [CW-1:0]          total_q;

	logic [23:0]            freq_q;
	logic signed [AngW-1:0] fang_q;
	logic [CW-1:0]          scan_q;
	logic [1:0]             nmatch_q;
	logic [IW-1:0]          hit_q;
	logic signed [AngW-1:0] hdiff_q;
	logic [2:0]             ev_q;

	logic                   cor_done;
	logic signed [AngW-1:0] cor_angle;
	logic                   div_start;
	logic                   div_done;
	logic signed [24:0]     div_q;
	logic signed [24:0]     div_num;
	logic [31:0]            div_den;

	logic [IW-1:0]          sidx;
	logic signed [AngW-1:0] d_scan;
	logic [AngW-1:0]        ad_scan;

	logic [MAX_SOURCES-1:0] talk_set;
	logic [8:0]             led_num;
	logic [20:0]            led_prod;

	assign pready = 1'b1;
	assign prdata = {24'd0, spread_q};
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_DONE);
	assign m_tdata  = {5'd0, ev_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) spread_q <= SpreadReset;
		else if (psel && penable && pwrite && paddr == 1'b0) spread_q <= pwdata[7:0];
	end

	dst_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(s_tvalid && s_tready),
		.pos_x(s_tdata[15:0]), .pos_y(s_tdata[31:16]),
		.done(cor_done), .angle(cor_angle)
	);

	// divisor is the tick count after this frame's increment
	assign div_num = 25'(signed'({1'b0, freq_q})) - 25'(signed'({1'b0, mean_q[hit_q]}));
	assign div_den = (ticks_q[hit_q] == 32'hFFFF_FFFF) ? ticks_q[hit_q]
		: ticks_q[hit_q] + 32'd1;
	dst_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_num), .divisor(div_den),
		.done(div_done), .quotient(div_q)
	);

	// scan: one entry per cycle through the shared wrap/compare path
	assign sidx    = scan_q[IW-1:0];
	assign d_scan  = wrap180(11'(fang_q) - 11'(ang_q[sidx]));
	assign ad_scan = d_scan[AngW-1] ? AngW'(-d_scan) : AngW'(d_scan);

	// LED number (180 - angle) / 20 by reciprocal: 3277 / 2^16, exact for 0..360
	assign led_num  = 9'(11'sd180 - 11'(fang_q));
	assign led_prod = led_num * 12'd3277;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_CORDIC;
			ST_CORDIC: if (cor_done) state_d = ST_ANGLE;
			ST_ANGLE:  state_d = ST_SCAN;
			ST_SCAN:   if (scan_q >= total_q) state_d = ST_APPLY;
			ST_APPLY:  state_d = (nmatch_q == 2'd1 && freq_q != 24'd0) ? ST_DIV : ST_DONE;
			ST_DIV:    if (div_done) state_d = ST_DONE;
			ST_DONE:   if (m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_start = (state_q == ST_APPLY) && (nmatch_q == 2'd1) && (freq_q != 24'd0);
	end

	// talking flags after this frame: only the new or singly matched entry
	always_comb begin
		talk_set = '0;
		if (nmatch_q == 2'd0) begin
			if (total_q < CW'(MAX_SOURCES)) talk_set[total_q[IW-1:0]] = 1'b1;
		end else if (nmatch_q == 2'd1) begin
			talk_set[hit_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			talk_q   <= '0;
			total_q  <= '0;
			scan_q   <= '0;
			nmatch_q <= '0;
			for (int i = 0; i < MAX_SOURCES; i++) begin
				ang_q[i] <= '0; led_q[i] <= '0; turns_q[i] <= '0;
				ticks_q[i] <= '0; mean_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (s_tvalid) freq_q <= s_tdata[55:32];
				ST_ANGLE: begin
					fang_q   <= cor_angle;
					scan_q   <= '0;
					nmatch_q <= '0;
				end
				ST_SCAN: if (scan_q < total_q) begin
					scan_q <= scan_q + 1'b1;
					if ({1'b0, ad_scan} < {2'b00, spread_q}) begin
						if (nmatch_q != 2'd2) nmatch_q <= nmatch_q + 2'd1;
						hit_q   <= sidx;
						hdiff_q <= d_scan;
					end
				end
				ST_APPLY: begin
					talk_q <= talk_set;
					if (nmatch_q == 2'd0) begin
						if (total_q >= CW'(MAX_SOURCES)) ev_q <= EV_FULL;
						else begin
							ang_q[total_q[IW-1:0]]   <= fang_q;
							led_q[total_q[IW-1:0]]   <= led_prod[20:16];
							turns_q[total_q[IW-1:0]] <= 16'd1;
							ticks_q[total_q[IW-1:0]] <= '0;
							mean_q[total_q[IW-1:0]]  <= '0;
							total_q <= total_q + 1'b1;
							ev_q    <= EV_NEW;
						end
					end else if (nmatch_q == 2'd1) begin
						if (!talk_q[hit_q]) begin
							if (turns_q[hit_q] != 16'hFFFF) turns_q[hit_q] <= turns_q[hit_q] + 16'd1;
							ang_q[hit_q] <= wrap180(11'(ang_q[hit_q]) + 11'(hdiff_q / 9'sd2));
							ev_q <= EV_NEW_TURN;
						end else ev_q <= EV_CONTINUE;
						ticks_q[hit_q] <= div_den;
					end else ev_q <= EV_AMBIGUOUS;
				end
				ST_DIV: if (div_done)
					mean_q[hit_q] <= 24'(25'(signed'({1'b0, mean_q[hit_q]})) + div_q);
				default: ;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("ready while result pending");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_SOURCES)) else $error("source count overflow");
	a_div_only_match: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> nmatch_q == 2'd1) else $error("divider started without match");
endmodule
`default_nettype wire

// ----- rtl/core/dst_cordic.sv -----
// Iterative vectoring CORDIC: one micro-rotation per cycle, whole-degree result.
`default_nettype none
module dst_cordic import dst_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [15:0]      pos_x,
	input  wire logic signed [15:0]      pos_y,
	output logic                         done,
	output logic signed [AngW-1:0]       angle
);
	// |u|, |v| <= 2^15 * 2^14 at start, grows by < 1.65 * sqrt(2): 32 bits signed plus margin
	logic signed [33:0] u_q, v_q;
	logic signed [ZW:0] z_q;
	logic [3:0]         step_q;
	logic               busy_q, xneg_q, yneg_q;
	logic signed [33:0] du, dv;
	logic signed [ZW:0] zc, m;
	logic [8:0]         mdeg;

	function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
			input logic [3:0] s);
		logic [33:0] a;
		a = v[33] ? 34'(-v) : 34'(v);
		a = a >> s;
		return v[33] ? -$signed(a) : $signed(a);
	endfunction

	assign du = shr_tz(v_q, step_q);
	assign dv = shr_tz(u_q, step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q    <= $signed({4'b0000, (pos_y[15] ? 16'(-pos_y) : 16'(pos_y)), 14'd0}) ;
			v_q    <= $signed({4'b0000, (pos_x[15] ? 16'(-pos_x) : 16'(pos_x)), 14'd0});
			z_q    <= '0;
			xneg_q <= pos_x[15];
			yneg_q <= pos_y[15];
		end else if (busy_q) begin
			if (v_q > 0) begin
				u_q <= u_q + du; v_q <= v_q - dv;
				z_q <= z_q + $signed({1'b0, atan_lut(step_q)});
			end else if (v_q < 0) begin
				u_q <= u_q - du; v_q <= v_q + dv;
				z_q <= z_q - $signed({1'b0, atan_lut(step_q)});
			end
		end
	end

	always_comb begin
		zc = z_q;
		if (zc < 0) zc = '0;
		if (zc > (ZW+1)'(90 * 65536)) zc = (ZW+1)'(90 * 65536);
		m = yneg_q ? (ZW+1)'(180 * 65536) - zc : zc;
		mdeg = m[24:16];
		angle = xneg_q ? -$signed(mdeg) : $signed(mdeg);
	end
endmodule
`default_nettype wire

// ----- rtl/core/dst_div.sv -----
// Restoring divider: signed 25-bit dividend by unsigned 32-bit divisor, one bit a cycle.
`default_nettype none
module dst_div import dst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [24:0] dividend,
	input  wire logic [31:0]        divisor,
	output logic                    done,
	output logic signed [24:0]      quotient
);
	logic [23:0] q_q;
	logic [32:0] r_q;
	logic [4:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [32:0] trial;
	logic [31:0] d_q;

	assign trial = {r_q[31:0], q_q[23]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend[24] ? 24'(-dividend) : dividend[23:0];
			neg_q <= dividend[24];
			r_q   <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[22:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[22:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
endmodule
`default_nettype wire
